>>> hw/rtl/internet_checksum_pseudo_header_unit_macros.svh
// Assertion macros shared by the checksum unit RTL.
`ifndef INTERNET_CHECKSUM_PSEUDO_HEADER_UNIT_MACROS_SVH
`define INTERNET_CHECKSUM_PSEUDO_HEADER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ICPH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define ICPH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/icph_pkg.sv
// Types, codes and helpers for the internet checksum unit.
package icph_pkg;

  // Packet kind codes
  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_TCP   = 2'd1;
  localparam logic [1:0] KIND_UDP   = 2'd2;

  // IP protocol numbers carried in the pseudo-header
  localparam logic [15:0] PROTO_TCP = 16'd6;
  localparam logic [15:0] PROTO_UDP = 16'd17;

  localparam logic [15:0] SUM_ALL_ONES = 16'hffff;
  localparam logic [15:0] ODD_BYTE_MASK = 16'hff00;

  // Input transaction
  typedef struct packed {
    logic [15:0] data_word;
    logic        first_word;
    logic        last_word;
    logic        odd_byte;
    logic [1:0]  packet_kind;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] segment_length;
  } icph_in_t;

  // Output transaction
  typedef struct packed {
    logic [15:0] checksum_value;
  } icph_out_t;

  // Contents of the input register: the word, its flags and the folded pseudo-header
  typedef struct packed {
    logic [15:0] data_word;
    logic        first_word;
    logic        last_word;
    logic        odd_byte;
    logic [1:0]  packet_kind;
    logic [15:0] pseudo_sum;
  } icph_stage_t;

  // Two 16-bit ones-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

>>> hw/rtl/icph_stream_if.sv
// Valid/ready channel carrying one payload struct per transaction.
interface icph_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/icph_pseudo_sum.sv
// Folded ones-complement sum of the TCP/UDP pseudo-header.
module icph_pseudo_sum
  import icph_pkg::*;
(
  input  logic [1:0]  packet_kind,
  input  logic [31:0] source_address,
  input  logic [31:0] dest_address,
  input  logic [15:0] segment_length,
  output logic [15:0] pseudo_sum
);

  logic        has_pseudo;
  logic [15:0] proto;
  logic [18:0] raw_sum;
  logic [16:0] fold1;
  logic [15:0] fold2;

  assign has_pseudo = (packet_kind == KIND_TCP) || (packet_kind == KIND_UDP);
  assign proto      = (packet_kind == KIND_TCP) ? PROTO_TCP : PROTO_UDP;

  // Six 16-bit terms, carries kept in the top bits
  assign raw_sum = {3'd0, source_address[31:16]} + {3'd0, source_address[15:0]}
                 + {3'd0, dest_address[31:16]}   + {3'd0, dest_address[15:0]}
                 + {3'd0, proto}                 + {3'd0, segment_length};

  // End-around carry, twice; second fold cannot overflow
  assign fold1 = {1'b0, raw_sum[15:0]} + {14'd0, raw_sum[18:16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

  assign pseudo_sum = has_pseudo ? fold2 : 16'd0;

endmodule

>>> hw/rtl/icph_accum.sv
// Running sum, latched kind and result register.
module icph_accum
  import icph_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  icph_stage_t stage_item,
  input  logic        result_ready,
  output logic        result_valid,
  output logic [15:0] result_value
);

  logic [15:0] running_sum;
  logic [1:0]  latched_kind;

  logic [15:0] base_sum;
  logic [15:0] word_masked;
  logic [15:0] acc;
  logic [1:0]  kind_now;
  logic [15:0] cs_raw;
  logic [15:0] cs_final;

  // A first word restarts from the pseudo-header
  assign base_sum = stage_item.first_word ? stage_item.pseudo_sum : running_sum;
  assign kind_now = stage_item.first_word ? stage_item.packet_kind : latched_kind;

  // Odd trailing byte: low half is padding
  assign word_masked = (stage_item.last_word && stage_item.odd_byte)
                     ? (stage_item.data_word & ODD_BYTE_MASK) : stage_item.data_word;

  assign acc    = oc_add(base_sum, word_masked);
  assign cs_raw = ~acc;

  // UDP sends zero as all ones
  assign cs_final = ((kind_now == KIND_UDP) && (cs_raw == 16'd0)) ? SUM_ALL_ONES : cs_raw;

  // Sum state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= 16'd0;
      latched_kind <= KIND_PLAIN;
    end else if (advance) begin
      latched_kind <= kind_now;
      running_sum  <= stage_item.last_word ? 16'd0 : acc;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && stage_item.last_word) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_item.last_word) begin
      result_value <= cs_final;
    end
  end

endmodule

>>> hw/rtl/internet_checksum_pseudo_header_unit.sv
// Top level of the internet checksum unit with TCP/UDP pseudo-header.
//
// Takes one 16-bit packet word per transaction (first byte in the high half)
// and keeps a ones-complement sum with end-around carry. On a first word the
// sum restarts; for TCP and UDP it starts from the pseudo-header (address
// halves, protocol number, segment length). On a last word one result
// transaction carries the complemented sum, with a UDP zero sent as 0xffff;
// an odd last word is padded with a zero low byte. An accepted word sits in
// the input register and is folded into the sum when it advances; its result
// (if any) is loaded into the result register at that same edge and offered
// from there. The unit takes one word per cycle, sustained; the only stall is
// a last word held while the previous result is still not taken.
module internet_checksum_pseudo_header_unit
  import icph_pkg::*;
(
  input logic          clk,
  input logic          rst,
  icph_stream_if.sink   words,
  icph_stream_if.source results
);

`include "internet_checksum_pseudo_header_unit_macros.svh"

  logic        stage_valid;
  icph_stage_t stage_item;
  icph_stage_t stage_next;
  logic [15:0] pseudo_sum;
  logic        result_free;
  logic        advance;
  logic        in_fire;
  logic        result_valid;
  logic [15:0] result_value;

  // Pseudo-header reduced before the input register
  icph_pseudo_sum u_pseudo (
    .packet_kind    (words.payload.packet_kind),
    .source_address (words.payload.source_address),
    .dest_address   (words.payload.dest_address),
    .segment_length (words.payload.segment_length),
    .pseudo_sum     (pseudo_sum)
  );

  always_comb begin
    stage_next.data_word   = words.payload.data_word;
    stage_next.first_word  = words.payload.first_word;
    stage_next.last_word   = words.payload.last_word;
    stage_next.odd_byte    = words.payload.odd_byte;
    stage_next.packet_kind = words.payload.packet_kind;
    stage_next.pseudo_sum  = pseudo_sum;
  end

  // Only a last word needs room in the result register
  assign result_free = !result_valid || results.ready;
  assign advance     = stage_valid && (!stage_item.last_word || result_free);
  assign words.ready = !stage_valid || advance;
  assign in_fire     = words.valid && words.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (words.ready) begin
      stage_valid <= words.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_item <= stage_next;
    end
  end

  icph_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .stage_item   (stage_item),
    .result_ready (results.ready),
    .result_valid (result_valid),
    .result_value (result_value)
  );

  assign results.valid                  = result_valid;
  assign results.payload.checksum_value = result_value;

  // Checks
  `ICPH_ASSERT_NEXT(a_last_gives_result, advance && stage_item.last_word, results.valid,
    "last word advanced without a result")
  `ICPH_ASSERT_NOW(a_no_overrun, stage_valid && stage_item.last_word && results.valid &&
    !results.ready, !in_fire, "input taken while a last word is blocked")
  `ICPH_ASSERT_NEXT(a_udp_single_nonzero, advance && stage_item.first_word &&
    stage_item.last_word && (stage_item.packet_kind == KIND_UDP),
    results.payload.checksum_value != 16'd0, "UDP checksum of zero sent")
  `ICPH_ASSERT_NEXT(a_plain_no_pseudo, in_fire && (words.payload.packet_kind != KIND_TCP) &&
    (words.payload.packet_kind != KIND_UDP), stage_item.pseudo_sum == 16'd0,
    "pseudo-header added for a kind without one")

endmodule

>>> tb/sv/internet_checksum_pseudo_header_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for the checksum unit: directed and random packet streams, checked per transaction.
module internet_checksum_pseudo_header_unit_tb
  import icph_pkg::*;
();

  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam int IDLE_LIMIT = 2000;   // cycles with no transaction before giving up
  localparam int TAIL_CYCLES = 8;
  localparam int RANDOM_WORDS = 1520;
  localparam int NUM_PHASES = 4;

  // Tracks the running ones-complement sum and the checksums still owed by the unit
  class checksum_tracker;
    logic [15:0] sum_reg;
    logic [1:0]  kind_reg;
    logic [15:0] expected_sums[$];
    int          errors;

    function new();
      sum_reg = '0;
      kind_reg = KIND_PLAIN;
      errors = 0;
    endfunction

    // 16-bit add with end-around carry
    function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
    endfunction

    // Word that brings the current partial sum to all ones
    function logic [15:0] closing_word();
      return ~sum_reg;
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Fold one accepted word into the sum; a last word queues its checksum
    function void add_word(icph_in_t w);
      logic [15:0] acc;
      logic [15:0] word;
      logic [15:0] csum;
      acc = sum_reg;
      word = w.data_word;
      if (w.first_word) begin
        acc = '0;
        kind_reg = w.packet_kind;
        if (w.packet_kind == KIND_TCP || w.packet_kind == KIND_UDP) begin
          acc = ones_add(acc, w.source_address[31:16]);
          acc = ones_add(acc, w.source_address[15:0]);
          acc = ones_add(acc, w.dest_address[31:16]);
          acc = ones_add(acc, w.dest_address[15:0]);
          acc = ones_add(acc, (w.packet_kind == KIND_TCP) ? PROTO_TCP : PROTO_UDP);
          acc = ones_add(acc, w.segment_length);
        end
      end
      // odd byte only matters on the last word
      if (w.last_word && w.odd_byte) word = word & ODD_BYTE_MASK;
      acc = ones_add(acc, word);
      if (w.last_word) begin
        csum = ~acc;
        if (kind_reg == KIND_UDP && csum == 16'h0000) csum = SUM_ALL_ONES;
        expected_sums.push_back(csum);
        sum_reg = '0;
      end else begin
        sum_reg = acc;
      end
    endfunction

    // Compare one result transaction with the oldest owed checksum
    task check_checksum(icph_out_t r);
      logic [15:0] want;
      if (expected_sums.size() == 0) begin
        report($sformatf("checksum %h with none outstanding", r.checksum_value));
      end else begin
        want = expected_sums.pop_front();
        if (r.checksum_value !== want)
          report($sformatf("checksum_value got %h want %h", r.checksum_value, want));
      end
    endtask
  endclass

  logic clk;
  logic rst = 1'b1;
  int   idle_pct = 0;
  int   words_sent = 0;

  checksum_tracker tracker = new();

  icph_stream_if #(.payload_t(icph_in_t))  words_if ();
  icph_stream_if #(.payload_t(icph_out_t)) results_if ();

  internet_checksum_pseudo_header_unit dut (
    .clk    (clk),
    .rst    (rst),
    .words  (words_if),
    .results(results_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap length: mostly short, now and then long
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_data();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'h0000;
    if (r < 16) return 16'hffff;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [31:0] pick_address();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h0000_0000;
    if (r < 20) return 32'hffff_ffff;
    return $urandom();
  endfunction

  function automatic logic [1:0] pick_kind();
    int r;
    r = $urandom_range(0, 19);
    if (r < 4) return KIND_PLAIN;
    if (r < 11) return KIND_TCP;
    if (r < 18) return KIND_UDP;
    return KIND_RESERVED;
  endfunction

  function automatic icph_in_t make_word(logic [15:0] data, bit is_first, bit is_last,
                                         bit is_odd, logic [1:0] kind, logic [31:0] src,
                                         logic [31:0] dst, logic [15:0] len);
    icph_in_t w;
    w.data_word = data;
    w.first_word = is_first;
    w.last_word = is_last;
    w.odd_byte = is_odd;
    w.packet_kind = kind;
    w.source_address = src;
    w.dest_address = dst;
    w.segment_length = len;
    return w;
  endfunction

  // Offer one word, optionally after an idle gap, and wait for the transaction
  task automatic send_word(icph_in_t w);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct) gap = pick_gap();
    if (gap > 0) begin
      words_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    words_if.valid <= 1'b1;
    words_if.payload <= w;
    do @(posedge clk); while (!words_if.ready);
    tracker.add_word(w);
    words_sent++;
  endtask

  // One packet; headless drops the first flag, restart repeats it midway,
  // zero_sum closes the packet so the sum ends at all ones
  task automatic send_packet(int nwords, logic [1:0] kind, bit headless, bit restart,
                             bit zero_sum);
    icph_in_t    w;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] len;
    int          r;
    src = pick_address();
    dst = pick_address();
    r = $urandom_range(0, 99);
    len = (r < 10) ? 16'h0000 : (r < 20) ? 16'hffff : 16'($urandom_range(0, 65535));
    for (int i = 0; i < nwords; i++) begin
      // fields the unit ignores still get random values
      w = make_word(pick_data(), 1'b0, 1'b0, 1'($urandom_range(0, 1)),
                    2'($urandom_range(0, 3)), $urandom(), $urandom(),
                    16'($urandom_range(0, 65535)));
      if (i == 0 && !headless) begin
        w.first_word = 1'b1;
        w.packet_kind = kind;
        w.source_address = src;
        w.dest_address = dst;
        w.segment_length = len;
      end
      if (restart && i > 0 && i == nwords / 2) begin
        w.first_word = 1'b1;
        w.packet_kind = pick_kind();
      end
      if (i == nwords - 1) begin
        w.last_word = 1'b1;
        if (zero_sum && !w.first_word) begin
          w.odd_byte = 1'b0;
          w.data_word = tracker.closing_word();
        end
      end
      send_word(w);
    end
  endtask

  // Result side: check each transaction, then stall at random
  initial begin
    int stall_left;
    stall_left = 0;
    results_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && results_if.valid && results_if.ready)
        tracker.check_checksum(results_if.payload);
      if (stall_left > 0) begin
        results_if.ready <= 1'b0;
        stall_left--;
      end else begin
        results_if.ready <= 1'b1;
        if ($urandom_range(0, 99) < idle_pct) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: too long without any transaction ends the run
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((words_if.valid && words_if.ready) || (results_if.valid && results_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus
  initial begin
    int phase_pct[NUM_PHASES];
    int target;
    int r;
    int nwords;
    phase_pct = '{0, 15, 40, 70};
    words_if.valid = 1'b0;
    words_if.payload = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, all kinds, odd bytes, restarts and headless packets
    send_word(make_word(16'hffff, 1'b1, 1'b1, 1'b0, KIND_TCP, 32'hffffffff, 32'hffffffff,
                        16'hffff));
    send_word(make_word(16'h0000, 1'b1, 1'b1, 1'b0, KIND_TCP, 32'h0, 32'h0, 16'h0000));
    // UDP whose sum is all ones: zero checksum goes out as all ones
    send_word(make_word(SUM_ALL_ONES - PROTO_UDP, 1'b1, 1'b1, 1'b0, KIND_UDP, 32'h0, 32'h0,
                        16'h0));
    // headless packet keeps the UDP kind
    send_word(make_word(16'h8000, 1'b0, 1'b0, 1'b0, KIND_PLAIN, 32'h0, 32'h0, 16'h0));
    send_word(make_word(16'h7fff, 1'b0, 1'b1, 1'b0, KIND_TCP, 32'hffffffff, 32'h0, 16'h0));
    // plain packets: no pseudo-header, zero checksum stays zero
    send_word(make_word(16'h0000, 1'b1, 1'b1, 1'b0, KIND_PLAIN, 32'hffffffff, 32'hffffffff,
                        16'hffff));
    send_word(make_word(16'hffff, 1'b1, 1'b1, 1'b0, KIND_PLAIN, 32'h12345678, 32'h9abcdef0,
                        16'h1));
    send_word(make_word(16'hffff, 1'b1, 1'b1, 1'b1, KIND_PLAIN, 32'h0, 32'h0, 16'h0));
    // reserved kind: no pseudo-header and no zero rule
    send_word(make_word(16'h1234, 1'b1, 1'b1, 1'b0, KIND_RESERVED, 32'hffffffff, 32'hffffffff,
                        16'hff));
    send_word(make_word(16'hffff, 1'b1, 1'b1, 1'b0, KIND_RESERVED, 32'hc0a80001, 32'h0a000001,
                        16'h8));
    // TCP: inner odd flag ignored, odd last word padded
    send_word(make_word(16'h4500, 1'b1, 1'b0, 1'b0, KIND_TCP, 32'hc0a80001, 32'hc0a800c7,
                        16'h0010));
    send_word(make_word(16'h00ff, 1'b0, 1'b0, 1'b1, KIND_UDP, 32'hffffffff, 32'hffffffff,
                        16'hffff));
    send_word(make_word(16'habcd, 1'b0, 1'b1, 1'b1, KIND_PLAIN, 32'h0, 32'h0, 16'h0));
    // restart: a second first word drops the partial sum
    send_word(make_word(16'h1111, 1'b1, 1'b0, 1'b0, KIND_UDP, 32'h01020304, 32'h05060708,
                        16'h0020));
    send_word(make_word(16'h2222, 1'b0, 1'b0, 1'b0, KIND_UDP, 32'h0, 32'h0, 16'h0));
    send_word(make_word(16'h3333, 1'b1, 1'b0, 1'b0, KIND_TCP, 32'hfffe0001, 32'h8000ffff,
                        16'hfffe));
    send_word(make_word(16'hfffe, 1'b0, 1'b1, 1'b0, KIND_PLAIN, 32'h0, 32'h0, 16'h0));
    // headless packet after a TCP packet
    send_word(make_word(16'h0001, 1'b0, 1'b0, 1'b0, KIND_PLAIN, 32'h0, 32'h0, 16'h0));
    send_word(make_word(16'h00ff, 1'b0, 1'b1, 1'b1, KIND_PLAIN, 32'h0, 32'h0, 16'h0));

    // Random packets in phases of rising idle pressure
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      idle_pct = phase_pct[phase];
      target = words_sent + RANDOM_WORDS / NUM_PHASES;
      while (words_sent < target) begin
        nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        r = $urandom_range(0, 99);
        send_packet(nwords, pick_kind(), r < 8, r >= 8 && r < 14,
                    $urandom_range(0, 99) < 8);
      end
      // hold the stream until every checksum is back
      words_if.valid <= 1'b0;
      do @(posedge clk); while (tracker.pending() != 0);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> internet_checksum_pseudo_header_unit.f
+incdir+hw/rtl
hw/rtl/icph_pkg.sv
hw/rtl/icph_stream_if.sv
hw/rtl/icph_pseudo_sum.sv
hw/rtl/icph_accum.sv
hw/rtl/internet_checksum_pseudo_header_unit.sv
tb/sv/internet_checksum_pseudo_header_unit_tb.sv
